[hw/rtl/qrfw_pkg.sv]
// ----------------------------------------------------------------------------
// qrfw_pkg
// Types, constants and the state encoding shared by the finder width
// detector's controller, datapath and top level.
// ----------------------------------------------------------------------------
package qrfw_pkg;

	// element widths and derived field widths
	localparam int WIDTH_BITS  = 20;
	localparam int SUM_BITS    = WIDTH_BITS + 3;
	localparam int EOFF_BITS   = WIDTH_BITS + 1;
	localparam int SPAN_BITS   = WIDTH_BITS + 2;
	localparam int CENTER_BITS = WIDTH_BITS + 2;
	localparam int BOFF_BITS   = WIDTH_BITS + 3;

	// ring position and the recent widths kept on the tap line
	localparam int WINDOW_DEPTH = 16;
	localparam int IDX_BITS     = $clog2(WINDOW_DEPTH);
	localparam int TAPS         = 6;

	// pair quantizer: dividend is 14 * pair + 1
	localparam int PAIR_BITS  = WIDTH_BITS + 1;
	localparam int DVD_BITS   = PAIR_BITS + 4;
	localparam int LANES      = 4;
	localparam int DIV_STEPS  = DVD_BITS;
	localparam int CNT_BITS   = $clog2(DIV_STEPS);
	localparam int CODE_BITS  = 8;

	localparam logic [SUM_BITS-1:0]  MIN_SUM    = SUM_BITS'(7);
	localparam logic [DVD_BITS-1:0]  Q_OFFSET   = DVD_BITS'(3);
	localparam logic [CODE_BITS-1:0] CODE_OUTER = CODE_BITS'(0);
	localparam logic [CODE_BITS-1:0] CODE_INNER = CODE_BITS'(2);

	// commands on the item channel
	localparam logic CMD_WIDTH = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic                  cmd;
		logic [WIDTH_BITS-1:0] width;
	} item_t;

	typedef struct packed {
		logic                   found;
		logic [EOFF_BITS-1:0]   end_half_offset;
		logic [SPAN_BITS-1:0]   inner_span;
		logic [CENTER_BITS-1:0] center_position;
		logic [BOFF_BITS-1:0]   begin_half_offset;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_RESULT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic start_div;
		logic div_step;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic do_div;
		logic div_last;
		logic out_free;
	} ctl_stat_t;

	// required code of each pair lane, outer pairs first and last
	function automatic logic [CODE_BITS-1:0] lane_code(input int lane);
		logic [CODE_BITS-1:0] c;
		c = CODE_OUTER;
		if (lane == 1 || lane == 2) begin
			c = CODE_INNER;
		end
		return c;
	endfunction

endpackage

[hw/rtl/qr_finder_width_detector.sv]
// ----------------------------------------------------------------------------
// qr_finder_width_detector
// Finder pattern (1:1:3:1:1) detector over bar and space widths of a line.
// A checked width is accepted, set up for the check, run through the 25-step
// restoring divide that the four pair lanes run side by side, then loaded into
// the output register once it is free; a clear, a disabled, an odd-position or a
// small-sum width skips the divide. A new width waits until the last is loaded.
// Reset: taps, sum and position clear to zero, enable sets to one.
// ----------------------------------------------------------------------------
module qr_finder_width_detector
	import qrfw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item_data,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result_data,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_enable
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// config word is always taken
	assign cfg_ready = 1'b1;

	// sequencer
	qrfw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	qrfw_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_data    (item_data),
		.cfg_valid    (cfg_valid),
		.cfg_enable   (cfg_enable),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

[hw/rtl/qrfw_ctrl.sv]
// ----------------------------------------------------------------------------
// qrfw_ctrl
// Sequencer for one width: accept, check setup, shared-step division over
// the four pair lanes, then hand the result word to the output register.
// ----------------------------------------------------------------------------
module qrfw_ctrl
	import qrfw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = stat.do_div ? ST_DIVIDE : ST_RESULT;
			end
			ST_DIVIDE: begin
				if (stat.div_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		item_ready    = 1'b0;
		cmd.accept    = 1'b0;
		cmd.start_div = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
			end
			ST_CHECK: begin
				cmd.start_div = stat.do_div;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_RESULT: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

endmodule

[hw/rtl/qrfw_dpath.sv]
// ----------------------------------------------------------------------------
// qrfw_dpath
// Width tap line, running five-width sum, position parity, enable register,
// four restoring divider lanes and the result output register.
// ----------------------------------------------------------------------------
module qrfw_dpath
	import qrfw_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item_data,
	input  logic      cfg_valid,
	input  logic      cfg_enable,
	input  ctl_cmd_t  cmd,
	output ctl_stat_t stat,
	output logic      result_valid,
	input  logic      result_ready,
	output result_t   result_data
);

	logic [WIDTH_BITS-1:0] tap_q [TAPS];
	logic [SUM_BITS-1:0]   sum_q;
	logic [IDX_BITS-1:0]   index_q;
	logic                  enable_q;
	logic                  chk_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DVD_BITS-1:0]   dvd_q [LANES];
	logic [SUM_BITS-1:0]   rem_q [LANES];
	logic                  valid_q;
	result_t               res_q;

	logic                  clear;
	logic [SUM_BITS-1:0]   sum_next;
	logic [DVD_BITS-1:0]   dvd_init [LANES];
	logic [SUM_BITS-1:0]   rem_next [LANES];
	logic                  lane_ok  [LANES];
	logic                  codes_ok;
	logic                  do_div;
	result_t               res_d;

	// round-up half of one width
	function automatic logic [WIDTH_BITS-1:0] half_up(input logic [WIDTH_BITS-1:0] w);
		logic [WIDTH_BITS:0] t;
		t = {1'b0, w} + (WIDTH_BITS+1)'(1);
		return t[WIDTH_BITS:1];
	endfunction

	assign clear = (item_data.cmd == CMD_CLEAR);

	// running sum drops the sixth width back and gains the previous one
	assign sum_next = sum_q - SUM_BITS'(tap_q[TAPS-1]) + SUM_BITS'(tap_q[0]);

	// enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_enable;
		end
	end

	// tap line, sum, position and check flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				tap_q[i] <= '0;
			end
			sum_q   <= '0;
			index_q <= '0;
			chk_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (clear) begin
				for (int i = 0; i < TAPS; i++) begin
					tap_q[i] <= '0;
				end
				sum_q   <= '0;
				index_q <= '0;
				chk_q   <= 1'b0;
			end else begin
				tap_q[0] <= item_data.width;
				for (int i = 1; i < TAPS; i++) begin
					tap_q[i] <= tap_q[i-1];
				end
				if (enable_q) begin
					sum_q <= sum_next;
				end
				index_q <= index_q + IDX_BITS'(1);
				chk_q   <= enable_q & ~index_q[0];
			end
		end
	end

	assign do_div = chk_q && (sum_q >= MIN_SUM);

	// dividend per lane: 14 * pair + 1
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [DVD_BITS-1:0] p;
			p = DVD_BITS'(tap_q[i+1]) + DVD_BITS'(tap_q[i+2]);
			dvd_init[i] = (p << 4) - (p << 1) + DVD_BITS'(1);
		end
	end

	// one restoring step per lane, quotient shifts into the dividend register
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [SUM_BITS:0] rsh;
			rsh = {rem_q[i], dvd_q[i][DVD_BITS-1]};
			if (rsh >= {1'b0, sum_q}) begin
				rem_next[i] = SUM_BITS'(rsh - {1'b0, sum_q});
			end else begin
				rem_next[i] = rsh[SUM_BITS-1:0];
			end
		end
	end

	// divider lanes and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.start_div) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (cmd.start_div) begin
				dvd_q[i] <= dvd_init[i];
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				dvd_q[i] <= {dvd_q[i][DVD_BITS-2:0],
					({rem_q[i], dvd_q[i][DVD_BITS-1]} >= {1'b0, sum_q})};
				rem_q[i] <= rem_next[i];
			end
		end
	end

	// quantized code check per lane
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [DVD_BITS-1:0] qm3;
			qm3 = dvd_q[i] - Q_OFFSET;
			lane_ok[i] = (dvd_q[i] >= Q_OFFSET) && (qm3[CODE_BITS:1] == lane_code(i));
		end
		codes_ok = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			codes_ok = codes_ok & lane_ok[i];
		end
	end

	// result word, zero on no match
	always_comb begin
		logic [SPAN_BITS-1:0]   span;
		logic [CENTER_BITS-1:0] center;
		span = SPAN_BITS'(tap_q[0]) + SPAN_BITS'(tap_q[1]) + SPAN_BITS'(tap_q[2]);
		center = CENTER_BITS'(span) + CENTER_BITS'(tap_q[3]);
		res_d = '0;
		if (do_div && codes_ok) begin
			res_d.found             = 1'b1;
			res_d.end_half_offset   = EOFF_BITS'(tap_q[0]) + EOFF_BITS'(half_up(tap_q[1]));
			res_d.inner_span        = span;
			res_d.center_position   = center;
			res_d.begin_half_offset = BOFF_BITS'(center) + BOFF_BITS'(tap_q[4])
				+ BOFF_BITS'(half_up(tap_q[5]));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q <= res_d;
		end
	end

	// status to controller
	assign stat.do_div   = do_div;
	assign stat.div_last = (cnt_q == CNT_BITS'(DIV_STEPS - 1));
	assign stat.out_free = ~valid_q | result_ready;

	assign result_valid = valid_q;
	assign result_data  = res_q;

endmodule
